// ===== src/cpmb_pkg.sv =====
// Shared types and constants of the CIGAR position map builder.
package cpmb_pkg;

  localparam int OPCODE_W   = 2;
  localparam int KIND_W     = 4;
  localparam int LEN_W      = 16;
  localparam int INDEX_W    = 12;
  localparam int ENTRY_W    = 17;
  localparam int REGION_W   = 13;
  localparam int PLEN_W     = 16;
  localparam int START_W    = 16;
  localparam int CURSOR_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPLY = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_M  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_I  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_D  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_N  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_S  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_H  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_EQ = 4'd7;
  localparam logic [KIND_W-1:0] KIND_X  = 4'd8;

  localparam logic [REG_IDX_W-1:0] REG_REGION_LENGTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PARTNER_LENGTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_STRAND  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALIGNMENT_START = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear_step;
    logic run_step;
    logic push;
  } cpmb_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                run_pending;
    logic                clear_pending;
    logic                clear_last;
    logic                run_last;
    logic                slot_free;
  } cpmb_status_t;

endpackage

// ===== src/cpmb_ifs.sv =====
// Valid/ready channel interfaces for item transfers and result transfers.
interface cpmb_in_if;
  import cpmb_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KIND_W-1:0]   op_kind;
  logic [LEN_W-1:0]    op_length;
  logic                last_op;
  logic [INDEX_W-1:0]  entry_index;

  modport source(output valid, opcode, op_kind, op_length, last_op, entry_index,
                 input ready);
  modport sink(input valid, opcode, op_kind, op_length, last_op, entry_index,
               output ready);
endinterface

interface cpmb_out_if;
  import cpmb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ENTRY_W-1:0] entry_value;
  logic                      write_overflow;
  logic                      map_ready;

  modport source(output valid, entry_value, write_overflow, map_ready, input ready);
  modport sink(input valid, entry_value, write_overflow, map_ready, output ready);
endinterface

// ===== src/cigar_position_map_builder.sv =====
// Top level of the CIGAR position map builder: register port, controller, datapath.
//
//  channel | role   | handshake        | contents
//  cmd     | sink   | valid/ready      | opcode, op_kind, op_length, last_op, entry_index
//  res     | source | valid/ready      | entry_value, write_overflow, map_ready
//  apb     | slave  | psel/penable     | region_length, partner_length, reverse_strand,
//          |        |                  | alignment_start
//
// One item at a time: accept, execute, respond.
// A match run writes each map entry in its own run step (run clipped to the map).
// A begin clears each entry in its own clear step, up to the highest entry written since the last clear.
// After reset a clearing pass over all MAP_DEPTH entries runs before the first item is taken.
// A stalled result holds the block in its respond step until the transfer completes.
module cigar_position_map_builder #(
  parameter int MAP_DEPTH     = 4096,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  cpmb_in_if.sink                           cmd,
  cpmb_out_if.source                        res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cpmb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cpmb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cpmb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import cpmb_pkg::*;

  logic [REGION_W-1:0] region_length;
  logic [PLEN_W-1:0]   partner_length;
  logic                reverse_strand;
  logic [START_W-1:0]  alignment_start;
  logic [REG_IDX_W-1:0] reg_idx;

  cpmb_cmd_t    ctrl_cmd;
  cpmb_status_t dp_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      region_length   <= '0;
      partner_length  <= '0;
      reverse_strand  <= 1'b0;
      alignment_start <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_REGION_LENGTH:   region_length   <= pwdata[REGION_W-1:0];
        REG_PARTNER_LENGTH:  partner_length  <= pwdata[PLEN_W-1:0];
        REG_REVERSE_STRAND:  reverse_strand  <= pwdata[0];
        REG_ALIGNMENT_START: alignment_start <= pwdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REGION_LENGTH:   prdata = CFG_DATA_W'(region_length);
      REG_PARTNER_LENGTH:  prdata = CFG_DATA_W'(partner_length);
      REG_REVERSE_STRAND:  prdata = CFG_DATA_W'(reverse_strand);
      REG_ALIGNMENT_START: prdata = CFG_DATA_W'(alignment_start);
      default:             prdata = '0;
    endcase
  end

  cpmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  cpmb_datapath #(
    .MAP_DEPTH     (MAP_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (ctrl_cmd),
    .status             (dp_status),
    .opcode             (cmd.opcode),
    .op_kind            (cmd.op_kind),
    .op_length          (cmd.op_length),
    .last_op            (cmd.last_op),
    .entry_index        (cmd.entry_index),
    .region_length      (region_length),
    .partner_length     (partner_length),
    .reverse_strand     (reverse_strand),
    .alignment_start    (alignment_start),
    .out_valid          (res.valid),
    .out_ready          (res.ready),
    .out_entry_value    (res.entry_value),
    .out_write_overflow (res.write_overflow),
    .out_map_ready      (res.map_ready)
  );

endmodule

// ===== src/cpmb_ctrl.sv =====
// Controller state machine of the position map builder.
module cpmb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cpmb_pkg::cpmb_status_t status,
  output cpmb_pkg::cpmb_cmd_t    cmd
);
  import cpmb_pkg::*;

  typedef enum logic [5:0] {
    S_BOOT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_CLEAR = 6'b001000,
    S_RUN   = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_BOOT: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
        if (status.opcode == OP_BEGIN && status.clear_pending) begin
          state_next = S_CLEAR;
        end else if (status.opcode == OP_APPLY && status.run_pending) begin
          state_next = S_RUN;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_RESP;
        end
      end
      S_RUN: begin
        cmd.run_step = 1'b1;
        if (status.run_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (status.slot_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_BOOT;
      end
    endcase
  end

endmodule

// ===== src/cpmb_datapath.sv =====
// Datapath: cursors, map memory, clear and run counters, result register.
module cpmb_datapath #(
  parameter int MAP_DEPTH     = 4096,
  parameter int POSITION_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cpmb_pkg::cpmb_cmd_t                     cmd,
  output cpmb_pkg::cpmb_status_t                  status,
  input  logic [cpmb_pkg::OPCODE_W-1:0]           opcode,
  input  logic [cpmb_pkg::KIND_W-1:0]             op_kind,
  input  logic [cpmb_pkg::LEN_W-1:0]              op_length,
  input  logic                                    last_op,
  input  logic [cpmb_pkg::INDEX_W-1:0]            entry_index,
  input  logic [cpmb_pkg::REGION_W-1:0]           region_length,
  input  logic [cpmb_pkg::PLEN_W-1:0]             partner_length,
  input  logic                                    reverse_strand,
  input  logic [cpmb_pkg::START_W-1:0]            alignment_start,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cpmb_pkg::ENTRY_W-1:0]     out_entry_value,
  output logic                                    out_write_overflow,
  output logic                                    out_map_ready
);
  import cpmb_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int CW = AW + 1;
  localparam int MW = POSITION_BITS + 1;
  localparam int XW = CURSOR_W + 1;
  localparam logic [POSITION_BITS-1:0] VMAX = {POSITION_BITS{1'b1}};

  // latched item
  logic [OPCODE_W-1:0] op_r;
  logic [KIND_W-1:0]   kind_r;
  logic [LEN_W-1:0]    len_r;
  logic                last_r;
  logic [INDEX_W-1:0]  idx_r;

  logic [CURSOR_W-1:0] ref_cur;
  logic [CURSOR_W-1:0] part_cur;
  logic                ready_flag;

  logic [CW-1:0] dirty_top;
  logic [CW-1:0] clr_cnt;
  logic [CW-1:0] clr_end;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_left;
  logic [POSITION_BITS-1:0] val;

  logic res_ovf;
  logic rd_in_range;

  logic [MW-1:0] map_mem [MAP_DEPTH];
  logic [MW-1:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic [XW-1:0] lim_x;
  logic [XW-1:0] start_x;
  logic [XW-1:0] end_x;
  logic [XW-1:0] stop_x;
  logic [XW-1:0] idx_x;
  logic          has_writes;
  logic          is_run;
  logic          is_part;
  logic          is_ref;
  logic          run_ovf;
  logic [XW-1:0] ref_sum;
  logic [XW-1:0] part_sum;
  logic [CURSOR_W-1:0] ref_sat;
  logic [CURSOR_W-1:0] part_sat;
  logic [POSITION_BITS-1:0] val_init;
  logic signed [ENTRY_W-1:0] read_value;
  logic [CURSOR_W-1:0] u_c;
  logic [CURSOR_W-1:0] pl_c;

  always_comb begin
    lim_x = (XW'(region_length) > XW'(MAP_DEPTH)) ? XW'(MAP_DEPTH) : XW'(region_length);
    start_x    = XW'(ref_cur);
    end_x      = start_x + XW'(len_r);
    stop_x     = (end_x > lim_x) ? lim_x : end_x;
    has_writes = start_x < stop_x;
    run_ovf    = (len_r != '0) && (end_x > lim_x);
    idx_x      = XW'(idx_r);
    is_run     = kind_r inside {KIND_M, KIND_EQ, KIND_X};
    is_part    = kind_r inside {KIND_I, KIND_S, KIND_H};
    is_ref     = kind_r inside {KIND_D, KIND_N};
    ref_sum    = start_x + XW'(len_r);
    part_sum   = XW'(part_cur) + XW'(len_r);
    ref_sat    = ref_sum[CURSOR_W] ? '1 : ref_sum[CURSOR_W-1:0];
    part_sat   = part_sum[CURSOR_W] ? '1 : part_sum[CURSOR_W-1:0];
    val_init   = ((part_cur >> POSITION_BITS) != '0) ? VMAX : part_cur[POSITION_BITS-1:0];
  end

  always_comb begin
    status               = '0;
    status.opcode        = op_r;
    status.run_pending   = is_run && has_writes;
    status.clear_pending = dirty_top != '0;
    status.clear_last    = clr_cnt == (clr_end - CW'(1));
    status.run_last      = wr_left == CW'(1);
    status.slot_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      kind_r <= op_kind;
      len_r  <= op_length;
      last_r <= last_op;
      idx_r  <= entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cur    <= '0;
      part_cur   <= '0;
      ready_flag <= 1'b0;
      dirty_top  <= '0;
      clr_cnt    <= '0;
      clr_end    <= CW'(MAP_DEPTH);
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (cmd.exec && op_r == OP_BEGIN) begin
        ref_cur    <= CURSOR_W'(alignment_start);
        part_cur   <= '0;
        ready_flag <= 1'b0;
        clr_cnt    <= '0;
        clr_end    <= dirty_top;
        dirty_top  <= '0;
      end
      if (cmd.exec && op_r == OP_APPLY) begin
        if (is_part || is_run) begin
          part_cur <= part_sat;
        end
        if (is_ref || is_run) begin
          ref_cur <= ref_sat;
        end
        if (is_run && has_writes && (stop_x[CW-1:0] > dirty_top)) begin
          dirty_top <= stop_x[CW-1:0];
        end
        if (last_r) begin
          ready_flag <= 1'b1;
        end
      end
    end
  end

  // run write sequencer and result flags
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      wr_addr     <= start_x[AW-1:0];
      wr_left     <= stop_x[CW-1:0] - start_x[CW-1:0];
      val         <= val_init;
      res_ovf     <= (op_r == OP_APPLY) && is_run && run_ovf;
      rd_in_range <= idx_x < lim_x;
    end else if (cmd.run_step) begin
      wr_addr <= wr_addr + AW'(1);
      wr_left <= wr_left - CW'(1);
      val     <= (val == VMAX) ? val : val + POSITION_BITS'(1);
    end
  end

  always_comb begin
    mem_we    = cmd.clear_step || cmd.run_step;
    mem_waddr = cmd.run_step ? wr_addr : clr_cnt[AW-1:0];
    mem_wdata = cmd.run_step ? {1'b1, val} : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.exec && op_r == OP_READ) begin
      rdata <= map_mem[idx_x[AW-1:0]];
    end
  end

  always_comb begin
    u_c  = CURSOR_W'(rdata[POSITION_BITS-1:0]);
    pl_c = CURSOR_W'(partner_length);
    if (!rd_in_range || !rdata[POSITION_BITS]) begin
      read_value = '1;
    end else if (reverse_strand) begin
      read_value = (u_c < pl_c) ? ENTRY_W'(pl_c - u_c - CURSOR_W'(1)) : '0;
    end else begin
      read_value = ENTRY_W'(u_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_entry_value    <= (op_r == OP_READ) ? read_value : '0;
      out_write_overflow <= res_ovf;
      out_map_ready      <= ready_flag;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the CIGAR position map builder: directed table, random alignments, predictor.
module tb_top;
  import cpmb_pkg::*;

  localparam int MAP_DEPTH    = 4096;
  localparam int POSITION_MAX = 65535;

  localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;
  localparam logic [KIND_W-1:0]   KIND_PAD   = 4'd6;
  localparam logic [KIND_W-1:0]   KIND_UNDEF = 4'd15;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KIND_W-1:0]   op_kind;
    logic [LEN_W-1:0]    op_length;
    logic                last_op;
    logic [INDEX_W-1:0]  entry_index;
  } cigar_item_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      write_overflow;
    logic                      map_ready;
  } map_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [REG_IDX_W-1:0]  cfg_reg;
    logic [CFG_DATA_W-1:0] cfg_value;
    cigar_item_t           item;
    logic                  typed;
    map_result_t           typed_result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cpmb_in_if  cmd_ch();
  cpmb_out_if res_ch();

  cigar_position_map_builder i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state
  logic signed [ENTRY_W-1:0] pos_map [MAP_DEPTH];
  logic [CURSOR_W-1:0]       ref_cur;
  logic [CURSOR_W-1:0]       part_cur;
  logic                      ready_seen;
  logic [REGION_W-1:0]       cfg_region;
  logic [PLEN_W-1:0]         cfg_plen;
  logic                      cfg_rev;
  logic [START_W-1:0]        cfg_start;

  map_result_t expected_results[$];
  stim_row_t   stim_rows[$];
  int          n_fail      = 0;
  int          n_sent      = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CURSOR_W-1:0] cursor_add(logic [CURSOR_W-1:0] a,
                                                     logic [LEN_W-1:0] b);
    logic [CURSOR_W:0] s;
    s = {1'b0, a} + b;
    return s[CURSOR_W] ? '1 : s[CURSOR_W-1:0];
  endfunction

  function automatic int map_limit();
    return (cfg_region > MAP_DEPTH) ? MAP_DEPTH : int'(cfg_region);
  endfunction

  function automatic map_result_t apply_item(cigar_item_t it);
    map_result_t               r;
    longint unsigned           lim;
    longint unsigned           start;
    longint unsigned           fin;
    longint unsigned           stop;
    longint unsigned           v;
    logic signed [ENTRY_W-1:0] e;
    r = '0;
    lim = map_limit();
    case (it.opcode)
      OP_BEGIN: begin
        for (int i = 0; i < MAP_DEPTH; i++) pos_map[i] = '1;
        ref_cur = cfg_start;
        part_cur = '0;
        ready_seen = 1'b0;
      end
      OP_APPLY: begin
        case (it.op_kind)
          KIND_I, KIND_S, KIND_H: part_cur = cursor_add(part_cur, it.op_length);
          KIND_D, KIND_N: ref_cur = cursor_add(ref_cur, it.op_length);
          KIND_M, KIND_EQ, KIND_X: begin
            start = ref_cur;
            fin = start + it.op_length;
            stop = (fin > lim) ? lim : fin;
            for (longint unsigned i = start; i < stop; i++) begin
              v = part_cur + (i - start);
              if (v > POSITION_MAX) v = POSITION_MAX;
              pos_map[i] = ENTRY_W'(v);
            end
            r.write_overflow = (it.op_length != 0) && (fin > lim);
            ref_cur = cursor_add(ref_cur, it.op_length);
            part_cur = cursor_add(part_cur, it.op_length);
          end
          default: ;
        endcase
        if (it.last_op) ready_seen = 1'b1;
      end
      OP_READ: begin
        r.entry_value = '1;
        if (it.entry_index < lim) begin
          e = pos_map[it.entry_index];
          if (!e[ENTRY_W-1]) begin
            v = e[ENTRY_W-2:0];
            if (cfg_rev)
              r.entry_value = (v < cfg_plen) ? ENTRY_W'(cfg_plen - v - 1) : '0;
            else
              r.entry_value = ENTRY_W'(v);
          end
        end
      end
      default: ;
    endcase
    r.map_ready = ready_seen;
    return r;
  endfunction

  function automatic cigar_item_t noise_item(logic [OPCODE_W-1:0] op);
    cigar_item_t it;
    it.opcode      = op;
    it.op_kind     = KIND_W'($urandom);
    it.op_length   = LEN_W'($urandom);
    it.last_op     = 1'($urandom);
    it.entry_index = INDEX_W'($urandom);
    return it;
  endfunction

  task automatic put_op(logic [OPCODE_W-1:0] op, logic [KIND_W-1:0] kind,
                        logic [LEN_W-1:0] len, logic last, logic [INDEX_W-1:0] idx);
    stim_row_t row;
    row = '0;
    row.item.opcode = op;
    row.item.op_kind = kind;
    row.item.op_length = len;
    row.item.last_op = last;
    row.item.entry_index = idx;
    stim_rows.push_back(row);
  endtask

  task automatic put_typed(logic signed [ENTRY_W-1:0] value, logic ovf, logic rdy);
    stim_rows[stim_rows.size()-1].typed = 1'b1;
    stim_rows[stim_rows.size()-1].typed_result.entry_value = value;
    stim_rows[stim_rows.size()-1].typed_result.write_overflow = ovf;
    stim_rows[stim_rows.size()-1].typed_result.map_ready = rdy;
  endtask

  task automatic put_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_reg = idx;
    row.cfg_value = value;
    stim_rows.push_back(row);
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_item(cigar_item_t it, logic typed, map_result_t typed_res);
    map_result_t predicted;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= it.opcode;
    cmd_ch.op_kind     <= it.op_kind;
    cmd_ch.op_length   <= it.op_length;
    cmd_ch.last_op     <= it.last_op;
    cmd_ch.entry_index <= it.entry_index;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_item(it);
    expected_results.push_back(typed ? typed_res : predicted);
    n_sent++;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    stored = '0;
    case (idx)
      REG_REGION_LENGTH: begin
        cfg_region = value[REGION_W-1:0];
        stored = cfg_region;
      end
      REG_PARTNER_LENGTH: begin
        cfg_plen = value[PLEN_W-1:0];
        stored = cfg_plen;
      end
      REG_REVERSE_STRAND: begin
        cfg_rev = value[0];
        stored = cfg_rev;
      end
      REG_ALIGNMENT_START: begin
        cfg_start = value[START_W-1:0];
        stored = cfg_start;
      end
      default: ;
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("prdata[%0d]: expected %0h, got %0h", idx, stored, prdata);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int seg, logic big);
    int region;
    int plen;
    int start;
    drain();
    if (big) begin
      case ($urandom_range(0, 2))
        0: region = MAP_DEPTH;
        1: region = 8191;
        default: region = $urandom_range(65, 8191);
      endcase
    end else begin
      region = (seg == 1) ? 0 : $urandom_range(1, 64);
    end
    if (seg == 0) plen = POSITION_MAX;
    else if (seg == 1) plen = 0;
    else if ($urandom_range(0, 3) == 0) plen = $urandom_range(0, POSITION_MAX);
    else plen = $urandom_range(0, 2 * region + 8);
    if (seg == 2) start = POSITION_MAX;
    else if ($urandom_range(0, 9) == 0) start = $urandom_range(0, POSITION_MAX);
    else start = $urandom_range(0, (region > 64 ? 64 : region) + 4);
    cfg_write(REG_REGION_LENGTH, region);
    cfg_write(REG_PARTNER_LENGTH, plen);
    cfg_write(REG_REVERSE_STRAND, $urandom_range(0, 1));
    cfg_write(REG_ALIGNMENT_START, start);
  endtask

  // one well-formed record: begin, CIGAR ops ending in last_op, then reads
  task automatic run_alignment();
    cigar_item_t it;
    int          n_ops;
    int          n_reads;
    int          lim;
    int          pick;
    int          top;
    lim = map_limit();
    top = (lim + 3 > MAP_DEPTH - 1) ? MAP_DEPTH - 1 : lim + 3;
    send_item(noise_item(OP_BEGIN), 1'b0, '0);
    n_ops = $urandom_range(1, 8);
    for (int k = 0; k < n_ops; k++) begin
      it = noise_item(OP_APPLY);
      pick = $urandom_range(0, 99);
      if (pick < 40) it.op_kind = KIND_M;
      else if (pick < 50) it.op_kind = KIND_EQ;
      else if (pick < 58) it.op_kind = KIND_X;
      else if (pick < 66) it.op_kind = KIND_I;
      else if (pick < 74) it.op_kind = KIND_D;
      else if (pick < 80) it.op_kind = KIND_N;
      else if (pick < 88) it.op_kind = KIND_S;
      else if (pick < 93) it.op_kind = KIND_H;
      else if (pick < 97) it.op_kind = KIND_PAD;
      else it.op_kind = KIND_W'($urandom_range(9, 15));
      if ($urandom_range(0, 19) != 0)
        it.op_length = LEN_W'($urandom_range(0, lim / 3 + 4));
      it.last_op = (k == n_ops - 1);
      send_item(it, 1'b0, '0);
    end
    n_reads = $urandom_range(1, 6);
    for (int k = 0; k < n_reads; k++) begin
      it = noise_item(OP_READ);
      if ($urandom_range(0, 19) != 0)
        it.entry_index = INDEX_W'($urandom_range(0, top));
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !rst && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    map_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", want.entry_value, res_ch.entry_value);
          n_fail++;
        end
        if (res_ch.write_overflow !== want.write_overflow) begin
          $error("write_overflow: expected %0b, got %0b",
                 want.write_overflow, res_ch.write_overflow);
          n_fail++;
        end
        if (res_ch.map_ready !== want.map_ready) begin
          $error("map_ready: expected %0b, got %0b", want.map_ready, res_ch.map_ready);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #120000000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int target;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= OP_BEGIN;
    cmd_ch.op_kind     <= KIND_M;
    cmd_ch.op_length   <= '0;
    cmd_ch.last_op     <= 1'b0;
    cmd_ch.entry_index <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    foreach (pos_map[i]) pos_map[i] = '1;
    ref_cur    = '0;
    part_cur   = '0;
    ready_seen = 1'b0;
    cfg_region = '0;
    cfg_plen   = '0;
    cfg_rev    = 1'b0;
    cfg_start  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    put_op(OP_READ, KIND_M, 0, 0, 0);              put_typed(-1, 0, 0);
    put_op(OP_READ, KIND_M, 0, 0, 4095);           put_typed(-1, 0, 0);
    put_cfg(REG_REGION_LENGTH, 16);
    put_cfg(REG_PARTNER_LENGTH, 20);
    put_cfg(REG_ALIGNMENT_START, 2);
    put_op(OP_BEGIN, KIND_M, 0, 0, 0);             put_typed(0, 0, 0);
    put_op(OP_APPLY, KIND_S, 3, 0, 0);             put_typed(0, 0, 0);
    put_op(OP_APPLY, KIND_H, 0, 0, 0);             put_typed(0, 0, 0);
    put_op(OP_APPLY, KIND_M, 4, 0, 0);
    put_op(OP_APPLY, KIND_I, 2, 0, 0);
    put_op(OP_APPLY, KIND_D, 1, 0, 0);
    put_op(OP_APPLY, KIND_N, 2, 0, 0);
    put_op(OP_APPLY, KIND_PAD, 5, 0, 0);
    put_op(OP_APPLY, KIND_UNDEF, 16'hFFFF, 0, 0);
    put_op(OP_APPLY, KIND_EQ, 3, 0, 0);
    put_op(OP_APPLY, KIND_X, 10, 1, 0);            put_typed(0, 1, 1);
    put_op(OP_READ, KIND_M, 0, 0, 2);
    put_op(OP_READ, KIND_M, 0, 0, 15);
    put_op(OP_READ, KIND_M, 0, 0, 16);             put_typed(-1, 0, 1);
    put_op(OP_NONE, KIND_X, 16'hFFFF, 1, 4095);    put_typed(0, 0, 1);
    put_op(OP_APPLY, KIND_M, 0, 0, 0);
    put_cfg(REG_REVERSE_STRAND, 1);
    put_cfg(REG_PARTNER_LENGTH, 5);
    put_op(OP_READ, KIND_M, 0, 0, 2);
    put_op(OP_READ, KIND_M, 0, 0, 9);
    put_op(OP_READ, KIND_M, 0, 0, 0);              put_typed(-1, 0, 1);
    put_cfg(REG_REVERSE_STRAND, 0);
    put_cfg(REG_REGION_LENGTH, MAP_DEPTH);
    put_cfg(REG_ALIGNMENT_START, 0);
    put_op(OP_BEGIN, KIND_M, 0, 0, 0);             put_typed(0, 0, 0);
    put_op(OP_APPLY, KIND_I, 16'hFFFF, 0, 0);
    put_op(OP_APPLY, KIND_I, 16'hFFFF, 0, 0);
    put_op(OP_APPLY, KIND_M, 16'hFFFF, 1, 0);
    put_op(OP_READ, KIND_M, 0, 0, 4095);
    put_op(OP_READ, KIND_M, 0, 0, 0);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].is_cfg) begin
        drain();
        cfg_write(stim_rows[r].cfg_reg, stim_rows[r].cfg_value);
      end else begin
        send_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].typed_result);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 76 : 0;
      rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 27 : 0;
      for (int seg = 0; seg < 7; seg++) begin
        configure(seg, seg == 6);
        target = n_sent + ((seg == 6) ? 21 : 32);
        while (n_sent < target) begin
          if ($urandom_range(0, 99) < 10)
            send_item(noise_item(OP_NONE - OPCODE_W'($urandom_range(0, 3))), 1'b0, '0);
          else
            run_alignment();
          if ($urandom_range(0, 49) == 0) drain();
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
